// ===== rtl/assert_macros.svh =====
// assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/amsd_pkg.sv =====
`timescale 1ns / 1ps

package amsd_pkg;

   localparam int SAMPLE_BITS_DEFAULT    = 16;
   localparam int BASE_FRAC_BITS_DEFAULT = 8;

   localparam int WEIGHT_W    = 16;
   localparam int DYN_LIM_W   = 17;
   localparam int DRIFT_LIM_W = 25;
   localparam int TIME_W      = 32;
   localparam int CONF_W      = 15;
   localparam int STATE_W     = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUO_W       = 14;
   localparam int NUM_W       = TIME_W + QUO_W;

   localparam int MIX_ROUND    = 32768;
   localparam int BREAK_FACTOR = 9;
   localparam int BREAK_SHIFT  = 2;

   localparam logic [WEIGHT_W-1:0]    WEIGHT_RESET    = 16'd62259;
   localparam logic [DYN_LIM_W-1:0]   DYN_LIM_RESET   = 17'd410;
   localparam logic [DRIFT_LIM_W-1:0] DRIFT_LIM_RESET = 25'd2048;
   localparam logic [DYN_LIM_W-1:0]   BRK_LIM_RESET   = 17'd820;
   localparam logic [TIME_W-1:0]      STABLE_MS_RESET = 32'd5000;

   localparam logic [CONF_W-1:0] CONF_MOVING    = 15'd2560;
   localparam logic [CONF_W-1:0] CONF_UNKNOWN   = 15'd5120;
   localparam logic [CONF_W-1:0] CONF_STAB_BASE = 15'd7680;
   localparam logic [CONF_W-1:0] CONF_SPAN      = 15'd14080;
   localparam logic [CONF_W-1:0] CONF_MONITOR   = 15'd24320;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASELINE_WEIGHT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOVING_DYNAMIC_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOVING_DRIFT_LIMIT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MONITOR_BREAK_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REQUIRED_STABLE_MS   = 3'd4;

   typedef enum logic [STATE_W-1:0] {
      PH_UNKNOWN,
      PH_MOVING,
      PH_STABILIZING,
      PH_MONITORING
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MIX,
      ST_NEWB,
      ST_SQ_DYN,
      ST_SQ_DRIFT,
      ST_ACC_DRIFT,
      ST_LIM_DYN,
      ST_LIM_BRK,
      ST_LIM_DRIFT,
      ST_LIM_END,
      ST_DECIDE,
      ST_NUM,
      ST_DIV,
      ST_SQRT_DYN,
      ST_SQRT_DRIFT,
      ST_FINISH
   } seq_state_type;

endpackage

// ===== rtl/amsd_if.sv =====
`timescale 1ns / 1ps

interface amsd_req_if #(
   parameter int SAMPLE_BITS = amsd_pkg::SAMPLE_BITS_DEFAULT
);
   logic                              valid;
   logic                              ready;
   logic signed [SAMPLE_BITS-1:0]     accel_x;
   logic signed [SAMPLE_BITS-1:0]     accel_y;
   logic signed [SAMPLE_BITS-1:0]     accel_z;
   logic [amsd_pkg::TIME_W-1:0]       now_ms;

   modport source (output valid, accel_x, accel_y, accel_z, now_ms, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, now_ms, output ready);
endinterface

interface amsd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [amsd_pkg::STATE_W-1:0]       mount_state;
   logic [amsd_pkg::CONF_W-1:0]        confidence;
   logic [amsd_pkg::DYN_LIM_W-1:0]     dynamic_mag;
   logic [amsd_pkg::DRIFT_LIM_W-1:0]   drift_mag;
   logic [amsd_pkg::TIME_W-1:0]        stable_ms;
   logic                               trusted;

   modport source (output valid, mount_state, confidence, dynamic_mag, drift_mag,
                   stable_ms, trusted, input ready);
   modport sink   (input valid, mount_state, confidence, dynamic_mag, drift_mag,
                   stable_ms, trusted, output ready);
endinterface

// ===== rtl/accel_mount_stability_detector_core.sv =====
`timescale 1ns / 1ps
// channel   dir   transfer
// req_ch    in    valid && ready, ready only while the sequencer is idle
// rsp_ch    out   valid && ready, one result per input transfer
// csr_*     in    one register write per cycle with csr_wr_en high
//
// each item runs through the shared multiplier (3 axes, 3 limits) and the shared
// two-bit-per-cycle square root stage, run twice; the confidence divider runs
// only when the result is stabilizing short of the required time
// reset is synchronous; baselines are seeded by the first sample
// a held result stalls the sequencer in its last state; no new item is taken meanwhile

`include "assert_macros.svh"

module accel_mount_stability_detector_core #(
   parameter int SAMPLE_BITS    = amsd_pkg::SAMPLE_BITS_DEFAULT,
   parameter int BASE_FRAC_BITS = amsd_pkg::BASE_FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   amsd_req_if.sink                            req_ch,
   amsd_rsp_if.source                          rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [amsd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [amsd_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int BW      = SAMPLE_BITS + BASE_FRAC_BITS;
   localparam int DW      = BW + 1;
   localparam int LIM_MW  = amsd_pkg::DRIFT_LIM_W + 1;
   localparam int MW      = (DW > LIM_MW) ? DW : LIM_MW;
   localparam int PW      = 2 * MW;
   localparam int SQ_W    = 2 * DW + 2;
   localparam int ROOT_W  = DW + 1;
   localparam int REM_W   = ROOT_W + 3;
   localparam int DYN_SQ_W   = 2 * amsd_pkg::DYN_LIM_W;
   localparam int DRIFT_SQ_W = 2 * amsd_pkg::DRIFT_LIM_W;
   localparam int CW_A    = SQ_W + amsd_pkg::BREAK_SHIFT;
   localparam int CW_B    = DYN_SQ_W + 2 * BASE_FRAC_BITS;
   localparam int CW_C    = DRIFT_SQ_W + 4;
   localparam int CW_AB   = (CW_A > CW_B) ? CW_A : CW_B;
   localparam int CW      = ((CW_AB > CW_C) ? CW_AB : CW_C) + 1;
   localparam int CNT_MAX = (ROOT_W > amsd_pkg::QUO_W) ? ROOT_W : amsd_pkg::QUO_W;
   localparam int CNT_W   = $clog2(CNT_MAX);
   localparam int EXT_W   = ROOT_W + amsd_pkg::DRIFT_LIM_W;
   localparam int AXES    = 3;
   localparam int AX_W    = 2;
   localparam logic [AX_W-1:0] AX_LAST = AX_W'(AXES - 1);
   localparam int TW      = amsd_pkg::TIME_W;
   localparam int QW      = amsd_pkg::QUO_W;

   // configuration
   logic [amsd_pkg::WEIGHT_W-1:0]    weight_ff;
   logic [amsd_pkg::DYN_LIM_W-1:0]   dyn_lim_ff;
   logic [amsd_pkg::DRIFT_LIM_W-1:0] drift_lim_ff;
   logic [amsd_pkg::DYN_LIM_W-1:0]   brk_lim_ff;
   logic [TW-1:0]                    req_ms_ff;

   // control
   amsd_pkg::seq_state_type state_ff, state_in;
   amsd_pkg::phase_type     phase_ff, phase_in;
   logic                    seeded_ff, seeded_in;
   logic [TW-1:0]           start_ff, start_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [BW-1:0]    raw_ff  [AXES];
   logic signed [BW-1:0]    base_ff [AXES];
   logic [TW-1:0]           now_ff;
   logic [AX_W-1:0]         ax_ff, ax_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [DW-1:0]    dd_ff, dd_in;
   logic signed [DW-1:0]    df_ff, df_in;
   logic [SQ_W-1:0]         s_dyn_ff, s_dyn_in;
   logic [SQ_W-1:0]         s_drift_ff, s_drift_in;
   logic [DYN_SQ_W-1:0]     dyn_sq_ff, dyn_sq_in;
   logic [DYN_SQ_W-1:0]     brk_sq_ff, brk_sq_in;
   logic [DRIFT_SQ_W-1:0]   drift_sq_ff, drift_sq_in;
   logic [TW-1:0]           elapsed_ff, elapsed_in;
   logic [amsd_pkg::CONF_W-1:0] conf_ff, conf_in;
   logic [TW-1:0]           div_rem_ff, div_rem_in;
   logic [QW-1:0]           div_low_ff, div_low_in;
   logic [QW-1:0]           div_q_ff, div_q_in;
   logic [SQ_W-1:0]         sq_n_ff, sq_n_in;
   logic [REM_W-1:0]        sq_rem_ff, sq_rem_in;
   logic [ROOT_W-1:0]       sq_root_ff, sq_root_in;
   logic [ROOT_W-1:0]       dyn_root_ff, dyn_root_in;
   logic [ROOT_W-1:0]       drift_root_ff, drift_root_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;

   // result register
   amsd_pkg::phase_type           out_phase_ff, out_phase_in;
   logic [amsd_pkg::CONF_W-1:0]   out_conf_ff, out_conf_in;
   logic [amsd_pkg::DYN_LIM_W-1:0]   out_dyn_ff, out_dyn_in;
   logic [amsd_pkg::DRIFT_LIM_W-1:0] out_drift_ff, out_drift_in;
   logic [TW-1:0]                 out_stable_ff, out_stable_in;

   logic                    accept;
   logic                    base_we;
   logic signed [BW-1:0]    raw_x, raw_y, raw_z;
   logic signed [BW-1:0]    raw_cur, base_cur;
   logic signed [DW-1:0]    mix_diff;
   logic signed [MW-1:0]    mul_a, mul_b;
   logic signed [PW-1:0]    mul_p;
   logic signed [PW-1:0]    mix_sum, mix_q, nb_full;
   logic signed [BW-1:0]    nb;

   logic [CW-1:0]           s_dyn_x, s_drift_x, dyn_lim_x, brk_lim_x, drift_lim_x;
   logic                    moving_now, break_now;
   logic [TW-1:0]           elapsed_old;
   amsd_pkg::phase_type     dec_phase;
   logic [TW-1:0]           dec_start, dec_elapsed;
   logic [amsd_pkg::CONF_W-1:0] dec_conf;
   logic                    dec_div;

   logic [amsd_pkg::NUM_W-1:0] num;
   logic [TW:0]             div_t, div_diff;
   logic                    div_ge;
   logic [QW-1:0]           div_q_next;

   logic [REM_W-1:0]        sq_cur, sq_trial, sq_diff;
   logic                    sq_ge;
   logic [ROOT_W-1:0]       sq_root_next;
   logic [EXT_W-1:0]        dyn_ext, drift_ext;

   assign accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == amsd_pkg::ST_IDLE);

   assign raw_x = {req_ch.accel_x, {BASE_FRAC_BITS{1'b0}}};
   assign raw_y = {req_ch.accel_y, {BASE_FRAC_BITS{1'b0}}};
   assign raw_z = {req_ch.accel_z, {BASE_FRAC_BITS{1'b0}}};

   assign raw_cur  = raw_ff[ax_ff];
   assign base_cur = base_ff[ax_ff];

   // baseline mix: raw + round((w * (b - raw)) / 2^16)
   assign mix_diff = DW'(base_cur) - DW'(raw_cur);
   assign mul_p    = mul_a * mul_b;
   assign mix_sum  = prod_ff + $signed(PW'(amsd_pkg::MIX_ROUND));
   assign mix_q    = mix_sum >>> amsd_pkg::WEIGHT_W;
   assign nb_full  = mix_q + PW'(raw_cur);
   assign nb       = nb_full[BW-1:0];
   assign base_we  = (state_ff == amsd_pkg::ST_NEWB);

   // threshold tests on exact squared sums
   assign s_dyn_x     = CW'(s_dyn_ff);
   assign s_drift_x   = CW'(s_drift_ff);
   assign dyn_lim_x   = CW'(dyn_sq_ff) << (2 * BASE_FRAC_BITS);
   assign brk_lim_x   = CW'(brk_sq_ff) << (2 * BASE_FRAC_BITS);
   assign drift_lim_x = CW'(drift_sq_ff);
   assign moving_now  = (s_dyn_x > dyn_lim_x) || (s_drift_x > drift_lim_x);
   assign break_now   = (s_dyn_x > brk_lim_x) ||
                        ((s_drift_x << amsd_pkg::BREAK_SHIFT) >
                         (drift_lim_x * CW'(amsd_pkg::BREAK_FACTOR)));
   assign elapsed_old = now_ff - start_ff;

   always_comb begin
      dec_phase = phase_ff;
      dec_start = start_ff;
      unique case (phase_ff)
         amsd_pkg::PH_UNKNOWN: begin
            dec_phase = moving_now ? amsd_pkg::PH_MOVING : amsd_pkg::PH_STABILIZING;
            dec_start = now_ff;
         end
         amsd_pkg::PH_MOVING: begin
            if (!moving_now) begin
               dec_phase = amsd_pkg::PH_STABILIZING;
               dec_start = now_ff;
            end
         end
         amsd_pkg::PH_STABILIZING: begin
            if (moving_now) begin
               dec_phase = amsd_pkg::PH_MOVING;
            end else if (elapsed_old >= req_ms_ff) begin
               dec_phase = amsd_pkg::PH_MONITORING;
            end
         end
         amsd_pkg::PH_MONITORING: begin
            if (break_now) begin
               dec_phase = amsd_pkg::PH_MOVING;
               dec_start = now_ff;
            end
         end
      endcase
      dec_elapsed = now_ff - dec_start;
      unique case (dec_phase)
         amsd_pkg::PH_MOVING:      dec_conf = amsd_pkg::CONF_MOVING;
         amsd_pkg::PH_STABILIZING: dec_conf = amsd_pkg::CONF_STAB_BASE + amsd_pkg::CONF_SPAN;
         amsd_pkg::PH_MONITORING:  dec_conf = amsd_pkg::CONF_MONITOR;
         amsd_pkg::PH_UNKNOWN:     dec_conf = amsd_pkg::CONF_UNKNOWN;
      endcase
      dec_div = (dec_phase == amsd_pkg::PH_STABILIZING) && (req_ms_ff != '0) &&
                (dec_elapsed < req_ms_ff);
   end

   // confidence fraction: restoring divider, one quotient bit per cycle
   assign num        = amsd_pkg::NUM_W'(elapsed_ff) * amsd_pkg::NUM_W'(amsd_pkg::CONF_SPAN);
   assign div_t      = {div_rem_ff, div_low_ff[QW-1]};
   assign div_diff   = div_t - {1'b0, req_ms_ff};
   assign div_ge     = (div_t >= {1'b0, req_ms_ff});
   assign div_q_next = {div_q_ff[QW-2:0], div_ge};

   // square root: two radicand bits per cycle
   assign sq_cur       = {sq_rem_ff[REM_W-3:0], sq_n_ff[SQ_W-1 -: 2]};
   assign sq_trial     = REM_W'({sq_root_ff, 2'b01});
   assign sq_ge        = (sq_cur >= sq_trial);
   assign sq_diff      = sq_cur - sq_trial;
   assign sq_root_next = {sq_root_ff[ROOT_W-2:0], sq_ge};

   assign dyn_ext   = EXT_W'(dyn_root_ff) >> BASE_FRAC_BITS;
   assign drift_ext = EXT_W'(drift_root_ff);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      seeded_in     = seeded_ff;
      start_in      = start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      ax_in         = ax_ff;
      prod_in       = prod_ff;
      dd_in         = dd_ff;
      df_in         = df_ff;
      s_dyn_in      = s_dyn_ff;
      s_drift_in    = s_drift_ff;
      dyn_sq_in     = dyn_sq_ff;
      brk_sq_in     = brk_sq_ff;
      drift_sq_in   = drift_sq_ff;
      elapsed_in    = elapsed_ff;
      conf_in       = conf_ff;
      div_rem_in    = div_rem_ff;
      div_low_in    = div_low_ff;
      div_q_in      = div_q_ff;
      sq_n_in       = sq_n_ff;
      sq_rem_in     = sq_rem_ff;
      sq_root_in    = sq_root_ff;
      dyn_root_in   = dyn_root_ff;
      drift_root_in = drift_root_ff;
      cnt_in        = cnt_ff;
      out_phase_in  = out_phase_ff;
      out_conf_in   = out_conf_ff;
      out_dyn_in    = out_dyn_ff;
      out_drift_in  = out_drift_ff;
      out_stable_in = out_stable_ff;
      mul_a         = '0;
      mul_b         = '0;

      unique case (state_ff)
         amsd_pkg::ST_IDLE: begin
            if (accept) begin
               ax_in      = '0;
               s_dyn_in   = '0;
               s_drift_in = '0;
               if (!seeded_ff) begin
                  seeded_in = 1'b1;
                  phase_in  = amsd_pkg::PH_STABILIZING;
                  start_in  = req_ch.now_ms;
               end
               state_in = amsd_pkg::ST_MIX;
            end
         end
         amsd_pkg::ST_MIX: begin
            mul_a    = MW'(mix_diff);
            mul_b    = MW'($signed({1'b0, weight_ff}));
            prod_in  = mul_p;
            state_in = amsd_pkg::ST_NEWB;
         end
         amsd_pkg::ST_NEWB: begin
            dd_in    = DW'(raw_cur) - DW'(nb);
            df_in    = DW'(nb) - DW'(base_cur);
            state_in = amsd_pkg::ST_SQ_DYN;
         end
         amsd_pkg::ST_SQ_DYN: begin
            mul_a    = MW'(dd_ff);
            mul_b    = MW'(dd_ff);
            prod_in  = mul_p;
            state_in = amsd_pkg::ST_SQ_DRIFT;
         end
         amsd_pkg::ST_SQ_DRIFT: begin
            s_dyn_in = s_dyn_ff + SQ_W'($unsigned(prod_ff));
            mul_a    = MW'(df_ff);
            mul_b    = MW'(df_ff);
            prod_in  = mul_p;
            state_in = amsd_pkg::ST_ACC_DRIFT;
         end
         amsd_pkg::ST_ACC_DRIFT: begin
            s_drift_in = s_drift_ff + SQ_W'($unsigned(prod_ff));
            if (ax_ff == AX_LAST) begin
               state_in = amsd_pkg::ST_LIM_DYN;
            end else begin
               ax_in    = ax_ff + AX_W'(1);
               state_in = amsd_pkg::ST_MIX;
            end
         end
         amsd_pkg::ST_LIM_DYN: begin
            mul_a    = MW'($signed({1'b0, dyn_lim_ff}));
            mul_b    = MW'($signed({1'b0, dyn_lim_ff}));
            prod_in  = mul_p;
            state_in = amsd_pkg::ST_LIM_BRK;
         end
         amsd_pkg::ST_LIM_BRK: begin
            dyn_sq_in = prod_ff[DYN_SQ_W-1:0];
            mul_a     = MW'($signed({1'b0, brk_lim_ff}));
            mul_b     = MW'($signed({1'b0, brk_lim_ff}));
            prod_in   = mul_p;
            state_in  = amsd_pkg::ST_LIM_DRIFT;
         end
         amsd_pkg::ST_LIM_DRIFT: begin
            brk_sq_in = prod_ff[DYN_SQ_W-1:0];
            mul_a     = MW'($signed({1'b0, drift_lim_ff}));
            mul_b     = MW'($signed({1'b0, drift_lim_ff}));
            prod_in   = mul_p;
            state_in  = amsd_pkg::ST_LIM_END;
         end
         amsd_pkg::ST_LIM_END: begin
            drift_sq_in = prod_ff[DRIFT_SQ_W-1:0];
            state_in    = amsd_pkg::ST_DECIDE;
         end
         amsd_pkg::ST_DECIDE: begin
            phase_in   = dec_phase;
            start_in   = dec_start;
            elapsed_in = dec_elapsed;
            conf_in    = dec_conf;
            if (dec_div) begin
               state_in = amsd_pkg::ST_NUM;
            end else begin
               sq_n_in    = s_dyn_ff;
               sq_rem_in  = '0;
               sq_root_in = '0;
               cnt_in     = CNT_W'(ROOT_W - 1);
               state_in   = amsd_pkg::ST_SQRT_DYN;
            end
         end
         amsd_pkg::ST_NUM: begin
            div_rem_in = num[amsd_pkg::NUM_W-1:QW];
            div_low_in = num[QW-1:0];
            div_q_in   = '0;
            cnt_in     = CNT_W'(QW - 1);
            state_in   = amsd_pkg::ST_DIV;
         end
         amsd_pkg::ST_DIV: begin
            div_rem_in = div_ge ? div_diff[TW-1:0] : div_t[TW-1:0];
            div_low_in = {div_low_ff[QW-2:0], 1'b0};
            div_q_in   = div_q_next;
            cnt_in     = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               conf_in    = amsd_pkg::CONF_STAB_BASE + amsd_pkg::CONF_W'(div_q_next);
               sq_n_in    = s_dyn_ff;
               sq_rem_in  = '0;
               sq_root_in = '0;
               cnt_in     = CNT_W'(ROOT_W - 1);
               state_in   = amsd_pkg::ST_SQRT_DYN;
            end
         end
         amsd_pkg::ST_SQRT_DYN: begin
            sq_n_in    = sq_n_ff << 2;
            sq_rem_in  = sq_ge ? sq_diff : sq_cur;
            sq_root_in = sq_root_next;
            cnt_in     = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               dyn_root_in = sq_root_next;
               sq_n_in     = s_drift_ff;
               sq_rem_in   = '0;
               sq_root_in  = '0;
               cnt_in      = CNT_W'(ROOT_W - 1);
               state_in    = amsd_pkg::ST_SQRT_DRIFT;
            end
         end
         amsd_pkg::ST_SQRT_DRIFT: begin
            sq_n_in    = sq_n_ff << 2;
            sq_rem_in  = sq_ge ? sq_diff : sq_cur;
            sq_root_in = sq_root_next;
            cnt_in     = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               drift_root_in = sq_root_next;
               state_in      = amsd_pkg::ST_FINISH;
            end
         end
         amsd_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               out_phase_in  = phase_ff;
               out_conf_in   = conf_ff;
               out_dyn_in    = dyn_ext[amsd_pkg::DYN_LIM_W-1:0];
               out_drift_in  = drift_ext[amsd_pkg::DRIFT_LIM_W-1:0];
               out_stable_in = ((phase_ff == amsd_pkg::PH_STABILIZING) ||
                                (phase_ff == amsd_pkg::PH_MONITORING)) ? elapsed_ff : '0;
               state_in      = amsd_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= amsd_pkg::ST_IDLE;
         phase_ff     <= amsd_pkg::PH_UNKNOWN;
         seeded_ff    <= 1'b0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         weight_ff    <= amsd_pkg::WEIGHT_RESET;
         dyn_lim_ff   <= amsd_pkg::DYN_LIM_RESET;
         drift_lim_ff <= amsd_pkg::DRIFT_LIM_RESET;
         brk_lim_ff   <= amsd_pkg::BRK_LIM_RESET;
         req_ms_ff    <= amsd_pkg::STABLE_MS_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         seeded_ff    <= seeded_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               amsd_pkg::CSR_BASELINE_WEIGHT:
                  weight_ff <= csr_data[amsd_pkg::WEIGHT_W-1:0];
               amsd_pkg::CSR_MOVING_DYNAMIC_LIMIT:
                  dyn_lim_ff <= csr_data[amsd_pkg::DYN_LIM_W-1:0];
               amsd_pkg::CSR_MOVING_DRIFT_LIMIT:
                  drift_lim_ff <= csr_data[amsd_pkg::DRIFT_LIM_W-1:0];
               amsd_pkg::CSR_MONITOR_BREAK_LIMIT:
                  brk_lim_ff <= csr_data[amsd_pkg::DYN_LIM_W-1:0];
               amsd_pkg::CSR_REQUIRED_STABLE_MS:
                  req_ms_ff <= csr_data[TW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         raw_ff[0] <= raw_x;
         raw_ff[1] <= raw_y;
         raw_ff[2] <= raw_z;
         now_ff    <= req_ch.now_ms;
      end
      // first sample seeds the baselines
      if (accept && !seeded_ff) begin
         base_ff[0] <= raw_x;
         base_ff[1] <= raw_y;
         base_ff[2] <= raw_z;
      end else if (base_we) begin
         base_ff[ax_ff] <= nb;
      end
      ax_ff         <= ax_in;
      prod_ff       <= prod_in;
      dd_ff         <= dd_in;
      df_ff         <= df_in;
      s_dyn_ff      <= s_dyn_in;
      s_drift_ff    <= s_drift_in;
      dyn_sq_ff     <= dyn_sq_in;
      brk_sq_ff     <= brk_sq_in;
      drift_sq_ff   <= drift_sq_in;
      elapsed_ff    <= elapsed_in;
      conf_ff       <= conf_in;
      div_rem_ff    <= div_rem_in;
      div_low_ff    <= div_low_in;
      div_q_ff      <= div_q_in;
      sq_n_ff       <= sq_n_in;
      sq_rem_ff     <= sq_rem_in;
      sq_root_ff    <= sq_root_in;
      dyn_root_ff   <= dyn_root_in;
      drift_root_ff <= drift_root_in;
      cnt_ff        <= cnt_in;
      out_phase_ff  <= out_phase_in;
      out_conf_ff   <= out_conf_in;
      out_dyn_ff    <= out_dyn_in;
      out_drift_ff  <= out_drift_in;
      out_stable_ff <= out_stable_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.mount_state = out_phase_ff;
   assign rsp_ch.confidence  = out_conf_ff;
   assign rsp_ch.dynamic_mag = out_dyn_ff;
   assign rsp_ch.drift_mag   = out_drift_ff;
   assign rsp_ch.stable_ms   = out_stable_ff;
   assign rsp_ch.trusted     = (out_phase_ff == amsd_pkg::PH_MONITORING);

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `ASSERT_IMPLIES(a_trusted_monitoring, clock, reset, rsp_ch.valid, rsp_ch.trusted == (rsp_ch.mount_state == 2'(amsd_pkg::PH_MONITORING)))
   `ASSERT_IMPLIES(a_moving_untimed, clock, reset, rsp_ch.valid && (rsp_ch.mount_state == 2'(amsd_pkg::PH_MOVING)), rsp_ch.stable_ms == '0)
   `ASSERT_IMPLIES(a_seeded_phase, clock, reset, seeded_ff, phase_ff != amsd_pkg::PH_UNKNOWN)

endmodule
